FILE: rtl/wrs_pkg.sv
// Package: shared types, constants and control codes for the tuner register shadow.
package wrs_pkg;

  // Default number of tuner registers in the bank
  localparam int RegCountDef = 16;
  // The device bus starts writes here
  localparam int WriteStart  = 2;
  // The device bus starts reads here
  localparam int ReadStart   = 'h0a;
  localparam int ValueW      = 16;
  localparam int ByteW       = 8;

  typedef enum logic [1:0] {
    CMD_WRITE      = 2'd0,
    CMD_READ_BEGIN = 2'd1,
    CMD_RX_BYTE    = 2'd2,
    CMD_QUERY      = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_TX_BYTE   = 2'd0,
    KIND_RD_COUNT  = 2'd1,
    KIND_RD_DONE   = 2'd2,
    KIND_QUERY     = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [3:0]        reg_index;
    logic [ValueW-1:0] wr_value;
    logic [ByteW-1:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ValueW-1:0] value;
    logic              last;
  } out_item_t;

  // Shadow read address source
  typedef enum logic [1:0] {
    RD_WALK,
    RD_FILL,
    RD_TARGET
  } rd_src_e;

  // Shadow write source
  typedef enum logic [1:0] {
    WR_NONE,
    WR_TARGET,
    WR_FILL_HI,
    WR_FILL_MERGE
  } wr_src_e;

  // Output register load source
  typedef enum logic [2:0] {
    OUT_NONE,
    OUT_COUNT,
    OUT_WR_HI,
    OUT_WR_LO,
    OUT_DONE,
    OUT_QUERY
  } out_src_e;

  typedef struct packed {
    logic     capture;
    logic     rd_en;
    rd_src_e  rd_src;
    wr_src_e  wr_src;
    out_src_e out_src;
    logic     walk_init;
    logic     walk_next;
    logic     win_arm;
    logic     fill_hi;
    logic     fill_lo;
  } dp_ctrl_t;

  typedef struct packed {
    cmd_e cmd;
    logic read_active;
    logic low_half_next;
    logic walk_at_target;
    logic fill_at_end;
  } dp_stat_t;

endpackage

FILE: rtl/wrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wrs_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/wrs_datapath.sv
// Datapath: item capture, shadow bank, read window registers and output register.
module wrs_datapath #(
  parameter int RegCount = wrs_pkg::RegCountDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wrs_pkg::in_item_t   in_item_i,
  input  wrs_pkg::dp_ctrl_t   ctrl_i,
  output wrs_pkg::dp_stat_t   stat_o,
  output wrs_pkg::out_item_t  out_item_o
);

  localparam int IdxW = (RegCount > 1) ? $clog2(RegCount) : 1;
  localparam int CntW = $clog2(RegCount + 1);
  localparam int VW   = (CntW > 4) ? CntW : 4;
  localparam int DW   = CntW + 1;
  localparam logic [IdxW-1:0] WrStartIdx = IdxW'(wrs_pkg::WriteStart % RegCount);
  localparam logic [IdxW-1:0] RdStartIdx = IdxW'(wrs_pkg::ReadStart % RegCount);
  localparam logic [IdxW-1:0] LastIdx    = IdxW'(RegCount - 1);
  localparam logic [VW-1:0]   RegCountV  = VW'(RegCount);
  localparam logic [DW-1:0]   RegCountD  = DW'(RegCount);

  // Reduce a 4-bit register index into the bank
  function automatic logic [IdxW-1:0] wrap_idx(input logic [3:0] idx);
    logic [VW-1:0] v;
    v = VW'(idx);
    for (int k = 0; k < 4; k++) begin
      if (v >= RegCountV) begin
        v = v - RegCountV;
      end
    end
    return IdxW'(v);
  endfunction

  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] i);
    return (i == LastIdx) ? '0 : i + IdxW'(1);
  endfunction

  logic [1:0]                 cmd_q;
  logic [IdxW-1:0]            target_q;
  logic [wrs_pkg::ValueW-1:0] wval_q;
  logic [wrs_pkg::ByteW-1:0]  rx_q;

  logic [IdxW-1:0]     walk_q, walk_d;
  logic [IdxW-1:0]     fill_q, fill_d;
  logic [IdxW-1:0]     end_q, end_d;
  logic                low_half_q, low_half_d;
  logic                active_q, active_d;
  logic [RegCount-1:0] valid_q, valid_d;
  logic                rd_valid_q;

  logic                       ram_we;
  logic [IdxW-1:0]            ram_waddr;
  logic [wrs_pkg::ValueW-1:0] ram_wdata;
  logic [IdxW-1:0]            ram_raddr;
  logic [wrs_pkg::ValueW-1:0] ram_rdata;
  logic [wrs_pkg::ValueW-1:0] rd_value;
  logic [wrs_pkg::ValueW-1:0] merged;
  logic [DW-1:0]              span;
  logic [wrs_pkg::ValueW-1:0] byte_count;

  wrs_pkg::out_item_t out_q, out_d;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q    <= in_item_i.cmd;
      target_q <= wrap_idx(in_item_i.reg_index);
      wval_q   <= in_item_i.wr_value;
      rx_q     <= in_item_i.rx_byte;
    end
  end

  // Unwritten entries read as zero
  assign rd_value = rd_valid_q ? ram_rdata : '0;
  assign merged   = rd_value | {{(wrs_pkg::ValueW - wrs_pkg::ByteW){1'b0}}, rx_q};

  always_comb begin
    unique case (ctrl_i.rd_src)
      wrs_pkg::RD_WALK: ram_raddr = walk_q;
      wrs_pkg::RD_FILL: ram_raddr = fill_q;
      default:          ram_raddr = target_q;
    endcase
  end

  always_comb begin
    ram_we    = 1'b1;
    ram_waddr = fill_q;
    ram_wdata = merged;
    unique case (ctrl_i.wr_src)
      wrs_pkg::WR_TARGET: begin
        ram_waddr = target_q;
        ram_wdata = wval_q;
      end
      wrs_pkg::WR_FILL_HI: begin
        ram_wdata = {rx_q, {wrs_pkg::ByteW{1'b0}}};
      end
      wrs_pkg::WR_FILL_MERGE: begin
        ram_wdata = merged;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  wrs_ram #(
    .Width(wrs_pkg::ValueW),
    .Depth(RegCount)
  ) u_shadow (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ctrl_i.rd_en),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Registers from the read start up to the target, with wrap
  always_comb begin
    if (target_q >= RdStartIdx) begin
      span = DW'(target_q) - DW'(RdStartIdx) + DW'(1);
    end else begin
      span = DW'(target_q) + RegCountD - DW'(RdStartIdx) + DW'(1);
    end
    byte_count = wrs_pkg::ValueW'({span, 1'b0});
  end

  always_comb begin
    walk_d     = walk_q;
    fill_d     = fill_q;
    end_d      = end_q;
    low_half_d = low_half_q;
    active_d   = active_q;
    valid_d    = valid_q;
    if (ram_we) begin
      valid_d[ram_waddr] = 1'b1;
    end
    if (ctrl_i.walk_init) begin
      walk_d = WrStartIdx;
    end else if (ctrl_i.walk_next) begin
      walk_d = next_idx(walk_q);
    end
    if (ctrl_i.win_arm) begin
      fill_d     = RdStartIdx;
      end_d      = target_q;
      low_half_d = 1'b0;
      active_d   = 1'b1;
    end
    if (ctrl_i.fill_hi) begin
      low_half_d = 1'b1;
    end
    if (ctrl_i.fill_lo) begin
      low_half_d = 1'b0;
      if (fill_q == end_q) begin
        active_d = 1'b0;
        fill_d   = RdStartIdx;
      end else begin
        fill_d = next_idx(fill_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q     <= '0;
      fill_q     <= RdStartIdx;
      end_q      <= '0;
      low_half_q <= 1'b0;
      active_q   <= 1'b0;
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      walk_q     <= walk_d;
      fill_q     <= fill_d;
      end_q      <= end_d;
      low_half_q <= low_half_d;
      active_q   <= active_d;
      valid_q    <= valid_d;
      if (ctrl_i.rd_en) begin
        rd_valid_q <= valid_q[ram_raddr];
      end
    end
  end

  always_comb begin
    out_d = out_q;
    unique case (ctrl_i.out_src)
      wrs_pkg::OUT_COUNT: begin
        out_d.kind  = wrs_pkg::KIND_RD_COUNT;
        out_d.value = byte_count;
        out_d.last  = 1'b0;
      end
      wrs_pkg::OUT_WR_HI: begin
        out_d.kind  = wrs_pkg::KIND_TX_BYTE;
        out_d.value = {{wrs_pkg::ByteW{1'b0}}, rd_value[wrs_pkg::ValueW-1 -: wrs_pkg::ByteW]};
        out_d.last  = 1'b0;
      end
      wrs_pkg::OUT_WR_LO: begin
        out_d.kind  = wrs_pkg::KIND_TX_BYTE;
        out_d.value = {{wrs_pkg::ByteW{1'b0}}, rd_value[wrs_pkg::ByteW-1:0]};
        out_d.last  = (walk_q == target_q);
      end
      wrs_pkg::OUT_DONE: begin
        out_d.kind  = wrs_pkg::KIND_RD_DONE;
        out_d.value = merged;
        out_d.last  = 1'b0;
      end
      wrs_pkg::OUT_QUERY: begin
        out_d.kind  = wrs_pkg::KIND_QUERY;
        out_d.value = rd_value;
        out_d.last  = 1'b0;
      end
      default: begin
        out_d = out_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_item_o = out_q;

  assign stat_o.cmd            = wrs_pkg::cmd_e'(cmd_q);
  assign stat_o.read_active    = active_q;
  assign stat_o.low_half_next  = low_half_q;
  assign stat_o.walk_at_target = (walk_q == target_q);
  assign stat_o.fill_at_end    = (fill_q == end_q);

endmodule

FILE: rtl/wrs_ctrl.sv
// Controller: state machine that sequences each command and owns output valid.
module wrs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  wrs_pkg::dp_stat_t stat_i,
  output wrs_pkg::dp_ctrl_t ctrl_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WR_RD,
    S_WR_HI,
    S_WR_LO,
    S_RX_MRG,
    S_QUERY
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   out_load;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    ctrl_o           = '0;
    ctrl_o.rd_src    = wrs_pkg::RD_TARGET;
    ctrl_o.wr_src    = wrs_pkg::WR_NONE;
    ctrl_o.out_src   = wrs_pkg::OUT_NONE;
    state_d          = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat_i.cmd)
          wrs_pkg::CMD_WRITE: begin
            ctrl_o.wr_src    = wrs_pkg::WR_TARGET;
            ctrl_o.walk_init = 1'b1;
            state_d          = S_WR_RD;
          end
          wrs_pkg::CMD_READ_BEGIN: begin
            if (out_free) begin
              ctrl_o.out_src = wrs_pkg::OUT_COUNT;
              ctrl_o.win_arm = 1'b1;
              state_d        = S_IDLE;
            end
          end
          wrs_pkg::CMD_RX_BYTE: begin
            // Drop bytes that arrive with no window armed
            if (!stat_i.read_active) begin
              state_d = S_IDLE;
            end else if (!stat_i.low_half_next) begin
              ctrl_o.wr_src  = wrs_pkg::WR_FILL_HI;
              ctrl_o.fill_hi = 1'b1;
              state_d        = S_IDLE;
            end else begin
              ctrl_o.rd_en  = 1'b1;
              ctrl_o.rd_src = wrs_pkg::RD_FILL;
              state_d       = S_RX_MRG;
            end
          end
          default: begin
            ctrl_o.rd_en  = 1'b1;
            ctrl_o.rd_src = wrs_pkg::RD_TARGET;
            state_d       = S_QUERY;
          end
        endcase
      end
      S_WR_RD: begin
        ctrl_o.rd_en  = 1'b1;
        ctrl_o.rd_src = wrs_pkg::RD_WALK;
        state_d       = S_WR_HI;
      end
      S_WR_HI: begin
        if (out_free) begin
          ctrl_o.out_src = wrs_pkg::OUT_WR_HI;
          state_d        = S_WR_LO;
        end
      end
      S_WR_LO: begin
        if (out_free) begin
          ctrl_o.out_src = wrs_pkg::OUT_WR_LO;
          if (stat_i.walk_at_target) begin
            state_d = S_IDLE;
          end else begin
            ctrl_o.walk_next = 1'b1;
            state_d          = S_WR_RD;
          end
        end
      end
      S_RX_MRG: begin
        // Hold the merge until the output can take the final value
        if (!stat_i.fill_at_end || out_free) begin
          ctrl_o.wr_src  = wrs_pkg::WR_FILL_MERGE;
          ctrl_o.fill_lo = 1'b1;
          if (stat_i.fill_at_end) begin
            ctrl_o.out_src = wrs_pkg::OUT_DONE;
          end
          state_d = S_IDLE;
        end
      end
      S_QUERY: begin
        if (out_free) begin
          ctrl_o.out_src = wrs_pkg::OUT_QUERY;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_load = (ctrl_o.out_src != wrs_pkg::OUT_NONE);

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/wrapping_register_window_shadow.sv
// Top level: shadow bank of tuner registers with write streaming and read window fill.
// One item is worked at a time. Every item is first taken in and then decoded. A write
// then walks the bank from register 2 to the target with wrap; for each register it
// reads the shadow, then sends the high and the low byte, so a write of n registers
// gives 2n bytes. A begin-read, a received high byte or a received byte with no window
// armed needs no shadow read; a query or any received low byte, the final one included,
// first reads the shadow. The single read port of the shadow RAM sets the pace. Output
// stalls hold any step that loads the output. The shadow is cleared at reset through
// per-entry valid bits, with no pass.
module wrapping_register_window_shadow #(
  parameter int RegCount = wrs_pkg::RegCountDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  wrs_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wrs_pkg::out_item_t out_item_o
);

  wrs_pkg::dp_ctrl_t ctrl;
  wrs_pkg::dp_stat_t stat;

  wrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  wrs_datapath #(
    .RegCount(RegCount)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_item_i (in_item_i),
    .ctrl_i    (ctrl),
    .stat_o    (stat),
    .out_item_o(out_item_o)
  );

endmodule
